// ===== sv/dbms_pkg.sv =====
`default_nettype none

package dbms_pkg;

    // field widths
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 8;
    localparam int ALT_W     = 21;
    localparam int FIX_W     = 4;
    localparam int HACC_W    = 32;
    localparam int TIME_W    = 48;
    localparam int BOX_W     = 2;
    localparam int STATE_W   = 3;
    localparam int CM_W      = 20;
    localparam int TOUT_W    = 16;
    localparam int TOUT_US_W = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_POLL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TO_EVT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LD_EVT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BOX    = 2'd3;

    // autopilot mode codes
    localparam logic [MODE_W-1:0] MODE_STAB   = 8'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 8'd3;
    localparam logic [MODE_W-1:0] MODE_GUIDED = 8'd4;
    localparam logic [MODE_W-1:0] MODE_RTL    = 8'd6;

    localparam logic [FIX_W-1:0] FIX_RTK = 4'd6;

    // box codes
    localparam logic [BOX_W-1:0] BOX_OTHER    = 2'd0;
    localparam logic [BOX_W-1:0] BOX_AIRBORNE = 2'd1;
    localparam logic [BOX_W-1:0] BOX_LANDED   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GPS_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HACC_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ARM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_ALT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_ALT    = 3'd4;

    // register reset values
    localparam logic [TOUT_W-1:0]    RST_GPS_TIMEOUT = 16'd100;
    localparam logic [TOUT_US_W-1:0] RST_TIMEOUT_US  = 36'd100_000_000;
    localparam logic [HACC_W-1:0]    RST_HACC_MAX    = 32'd1000;
    localparam logic [CM_W-1:0]      RST_TAKEOFF_ALT = 20'd2000;
    localparam logic [CM_W-1:0]      RST_LAND_ALT    = 20'd2000;

    localparam logic [TOUT_US_W-1:0] USEC_PER_SEC = 36'd1_000_000;
    localparam logic [CM_W:0]        ONE_METRE_CM = 21'd100;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [MODE_W-1:0]       ap_mode;
        logic                    is_armed;
        logic signed [ALT_W-1:0] altitude_cm;
        logic [FIX_W-1:0]        gps_fix;
        logic [HACC_W-1:0]       gps_hacc;
        logic [TIME_W-1:0]       now_us;
        logic                    ready_flag;
        logic [BOX_W-1:0]        box_code;
    } in_word_t;

    typedef struct packed {
        logic [STATE_W-1:0] mission_state;
        logic               mode_cmd_valid;
        logic [MODE_W-1:0]  mode_cmd;
        logic               arm_cmd;
        logic               takeoff_cmd_valid;
        logic [CM_W-1:0]    takeoff_target_cm;
    } out_word_t;

    typedef struct packed {
        logic [TOUT_US_W-1:0] gps_timeout_us;
        logic [HACC_W-1:0]    gps_hacc_max;
        logic                 auto_arm;
        logic [CM_W-1:0]      takeoff_alt_cm;
        logic [CM_W-1:0]      land_alt_cm;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/dbms_in_if.sv =====
`default_nettype none

interface dbms_in_if;
    import dbms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [MODE_W-1:0]       ap_mode;
    logic                    is_armed;
    logic signed [ALT_W-1:0] altitude_cm;
    logic [FIX_W-1:0]        gps_fix;
    logic [HACC_W-1:0]       gps_hacc;
    logic [TIME_W-1:0]       now_us;
    logic                    ready_flag;
    logic [BOX_W-1:0]        box_code;

    modport source (
        output valid, kind, ap_mode, is_armed, altitude_cm, gps_fix, gps_hacc, now_us,
               ready_flag, box_code,
        input  ready
    );

    modport sink (
        input  valid, kind, ap_mode, is_armed, altitude_cm, gps_fix, gps_hacc, now_us,
               ready_flag, box_code,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/dbms_out_if.sv =====
`default_nettype none

interface dbms_out_if;
    import dbms_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] mission_state;
    logic               mode_cmd_valid;
    logic [MODE_W-1:0]  mode_cmd;
    logic               arm_cmd;
    logic               takeoff_cmd_valid;
    logic [CM_W-1:0]    takeoff_target_cm;

    modport source (
        output valid, mission_state, mode_cmd_valid, mode_cmd, arm_cmd, takeoff_cmd_valid,
               takeoff_target_cm,
        input  ready
    );

    modport sink (
        input  valid, mission_state, mode_cmd_valid, mode_cmd, arm_cmd, takeoff_cmd_valid,
               takeoff_target_cm,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/drone_box_mission_sequencer.sv =====
// Takeoff and landing sequencer for a drone working with a docking box. Each input word (poll,
// takeoff-ready event, landing-ready event or box update) gives exactly one result word carrying
// the new mission state and any mode, arm and takeoff commands. One word is accepted every clock
// cycle while the result port is not stalled; each word is captured in the input register at
// acceptance and its result is loaded into the result register when that register is free or
// draining. The rate is set by the update of the sequencer state, which every word reads and
// writes. Configuration writes take effect once the written register is updated; the GPS
// timeout in microseconds is formed from the seconds register by one registered multiply.
`default_nettype none

module drone_box_mission_sequencer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dbms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dbms_pkg::CFG_DATA_W-1:0]  cfg_data,
    dbms_in_if.sink                               in_ch,
    dbms_out_if.source                            out_ch
);
    import dbms_pkg::*;

    cfg_t      cfg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    out_word_t res;
    logic      advance;
    logic      in_take;

    // a word moves to the result register whenever that register is free or draining
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    dbms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbms_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.kind        <= in_ch.kind;
            in_word_reg.ap_mode     <= in_ch.ap_mode;
            in_word_reg.is_armed    <= in_ch.is_armed;
            in_word_reg.altitude_cm <= in_ch.altitude_cm;
            in_word_reg.gps_fix     <= in_ch.gps_fix;
            in_word_reg.gps_hacc    <= in_ch.gps_hacc;
            in_word_reg.now_us      <= in_ch.now_us;
            in_word_reg.ready_flag  <= in_ch.ready_flag;
            in_word_reg.box_code    <= in_ch.box_code;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= res;
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.mission_state     = out_word_reg.mission_state;
    assign out_ch.mode_cmd_valid    = out_word_reg.mode_cmd_valid;
    assign out_ch.mode_cmd          = out_word_reg.mode_cmd;
    assign out_ch.arm_cmd           = out_word_reg.arm_cmd;
    assign out_ch.takeoff_cmd_valid = out_word_reg.takeoff_cmd_valid;
    assign out_ch.takeoff_target_cm = out_word_reg.takeoff_target_cm;

    // a waiting result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !advance)
        else $error("result overwritten before it was taken");

    // a held input word is not replaced before it is processed
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> !in_take)
        else $error("input word replaced before processing");

    // every processed word shows up as a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word gave no result");

endmodule

`default_nettype wire

// ===== sv/dbms_cfg.sv =====
`default_nettype none

module dbms_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dbms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dbms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dbms_pkg::cfg_t                          cfg
);
    import dbms_pkg::*;

    logic [TOUT_W-1:0]    gps_timeout_reg;
    logic [TOUT_US_W-1:0] timeout_us_reg;
    logic [TOUT_US_W-1:0] timeout_us_next;
    logic [HACC_W-1:0]    hacc_max_reg;
    logic                 auto_arm_reg;
    logic [CM_W-1:0]      takeoff_alt_reg;
    logic [CM_W-1:0]      land_alt_reg;

    // timeout in microseconds, product registered continuously from the seconds register
    assign timeout_us_next = TOUT_US_W'(gps_timeout_reg) * USEC_PER_SEC;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_timeout_reg <= RST_GPS_TIMEOUT;
            timeout_us_reg  <= RST_TIMEOUT_US;
            hacc_max_reg    <= RST_HACC_MAX;
            auto_arm_reg    <= 1'b0;
            takeoff_alt_reg <= RST_TAKEOFF_ALT;
            land_alt_reg    <= RST_LAND_ALT;
        end
        else
        begin
            timeout_us_reg <= timeout_us_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GPS_TIMEOUT: gps_timeout_reg <= cfg_data[TOUT_W-1:0];
                    REG_HACC_MAX:    hacc_max_reg    <= cfg_data[HACC_W-1:0];
                    REG_AUTO_ARM:    auto_arm_reg    <= cfg_data[0];
                    REG_TAKEOFF_ALT: takeoff_alt_reg <= cfg_data[CM_W-1:0];
                    REG_LAND_ALT:    land_alt_reg    <= cfg_data[CM_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    assign cfg.gps_timeout_us = timeout_us_reg;
    assign cfg.gps_hacc_max   = hacc_max_reg;
    assign cfg.auto_arm       = auto_arm_reg;
    assign cfg.takeoff_alt_cm = takeoff_alt_reg;
    assign cfg.land_alt_cm    = land_alt_reg;

endmodule

`default_nettype wire

// ===== sv/dbms_seq.sv =====
`default_nettype none

module dbms_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire dbms_pkg::in_word_t  word,
    input  wire dbms_pkg::cfg_t      cfg,
    output dbms_pkg::out_word_t      res
);
    import dbms_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        ST_STANDBY   = 3'd0,
        ST_TO_REQ    = 3'd1,
        ST_TO_READY  = 3'd2,
        ST_AIRBORNE  = 3'd3,
        ST_LD_REQ    = 3'd4,
        ST_LANDING   = 3'd5,
        ST_TOUCHDOWN = 3'd6,
        ST_LANDED    = 3'd7
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] wait_start_reg;
    logic [TIME_W-1:0] wait_start_next;
    logic [BOX_W-1:0]  box_reg;
    logic [BOX_W-1:0]  box_next;

    logic                    gps_bad;
    logic [TIME_W-1:0]       elapsed;
    logic                    timed_out;
    logic signed [ALT_W:0]   alt_ext;
    logic signed [ALT_W:0]   takeoff_ext;
    logic signed [ALT_W:0]   land_ext;
    logic [CM_W:0]           tgt_sum;
    logic [CM_W-1:0]         tgt;

    // gps quality and timeout
    assign gps_bad   = (word.gps_fix != FIX_RTK) || (word.gps_hacc > cfg.gps_hacc_max);
    assign elapsed   = word.now_us - wait_start_reg;
    assign timed_out = elapsed >= {{(TIME_W-TOUT_US_W){1'b0}}, cfg.gps_timeout_us};

    // altitude compares: altitude sign extended by one bit, configured altitudes zero extended by two
    assign alt_ext     = {word.altitude_cm[ALT_W-1], word.altitude_cm};
    assign takeoff_ext = $signed({2'b00, cfg.takeoff_alt_cm});
    assign land_ext    = $signed({2'b00, cfg.land_alt_cm});

    // takeoff target, one metre above the configured altitude, saturating
    assign tgt_sum = {1'b0, cfg.takeoff_alt_cm} + ONE_METRE_CM;
    assign tgt     = tgt_sum[CM_W] ? {CM_W{1'b1}} : tgt_sum[CM_W-1:0];

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        wait_start_next = wait_start_reg;
        box_next        = box_reg;
        res             = '0;
        case (word.kind)
            KIND_POLL:
            begin
                if (word.ap_mode == MODE_STAB)
                begin
                    state_next = ST_STANDBY;
                end
                else
                begin
                    unique case (state_reg)
                        ST_STANDBY:
                        begin
                            if (word.ap_mode == MODE_GUIDED)
                                state_next = ST_TO_REQ;
                        end
                        ST_TO_READY:
                        begin
                            if (word.ap_mode == MODE_GUIDED)
                            begin
                                if (gps_bad)
                                begin
                                    if (wait_start_reg == '0)
                                        wait_start_next = word.now_us;
                                    else if (timed_out)
                                        state_next = ST_LANDED;
                                end
                                else
                                begin
                                    wait_start_next = '0;
                                    res.arm_cmd     = cfg.auto_arm;
                                    if (word.is_armed)
                                    begin
                                        res.takeoff_cmd_valid = 1'b1;
                                        res.takeoff_target_cm = tgt;
                                        if (alt_ext >= takeoff_ext)
                                            state_next = ST_AIRBORNE;
                                    end
                                end
                            end
                        end
                        ST_AIRBORNE:
                        begin
                            if (box_reg == BOX_AIRBORNE)
                            begin
                                if (word.ap_mode == MODE_GUIDED)
                                begin
                                    res.mode_cmd_valid = 1'b1;
                                    res.mode_cmd       = MODE_AUTO;
                                end
                                if ((word.ap_mode == MODE_AUTO) && (alt_ext <= land_ext))
                                    state_next = ST_LD_REQ;
                            end
                        end
                        ST_LD_REQ:
                        begin
                            if ((word.ap_mode == MODE_AUTO) || (word.ap_mode == MODE_RTL))
                            begin
                                res.mode_cmd_valid = 1'b1;
                                res.mode_cmd       = MODE_GUIDED;
                            end
                        end
                        ST_LANDING:
                        begin
                            if (!word.is_armed)
                                state_next = ST_TOUCHDOWN;
                        end
                        ST_TOUCHDOWN:
                        begin
                            if (!word.is_armed)
                                state_next = ST_LANDED;
                        end
                        ST_LANDED:
                        begin
                            if (box_reg == BOX_LANDED)
                                state_next = ST_STANDBY;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_TO_EVT:
            begin
                if (word.ready_flag && (state_reg == ST_TO_REQ))
                    state_next = ST_TO_READY;
            end
            KIND_LD_EVT:
            begin
                if (word.ready_flag && (state_reg == ST_LD_REQ))
                    state_next = ST_LANDING;
            end
            default:
            begin
                box_next = word.box_code;
            end
        endcase
        res.mission_state = state_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_STANDBY;
            wait_start_reg <= '0;
            box_reg        <= BOX_OTHER;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            wait_start_reg <= wait_start_next;
            box_reg        <= box_next;
        end
    end

    // stabilize always lands in standby
    a_stab_standby: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (word.kind == KIND_POLL) && (word.ap_mode == MODE_STAB)
        |=> state_reg == ST_STANDBY)
        else $error("stabilize poll did not force standby");

    // state only moves when a word is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(wait_start_reg) && $stable(box_reg))
        else $error("sequencer state moved without a word");

    // a box update leaves the state and gps wait alone
    a_box_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (word.kind == KIND_BOX)
        |=> $stable(state_reg) && $stable(wait_start_reg))
        else $error("box update changed the mission state");

    // takeoff is only commanded from takeoff ready
    a_takeoff_src: assert property (@(posedge clk) disable iff (!rst_n)
        res.takeoff_cmd_valid |-> (state_reg == ST_TO_READY) && (word.kind == KIND_POLL))
        else $error("takeoff command outside takeoff ready");

endmodule

`default_nettype wire
